/* hw/rtl/mrt_pkg.sv */
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and constants for the mesh route table.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam logic [31:0] TIMEOUT_RESET = 32'd120000;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_SWEEP  = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] node_id;
    logic [31:0] first_hop;
    logic [7:0]  hop_count;
    logic [4:0]  entry_index;
    logic [31:0] now;
  } request_t;

  typedef struct packed {
    logic        found;
    logic        changed;
    logic [31:0] route_node_id;
    logic [31:0] route_first_hop;
    logic [7:0]  route_hops;
    logic [5:0]  entry_count;
  } response_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] via;
    logic [7:0]  hops;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_WRITE,
    CELL_STAMP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   data;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_INSERT,
    ST_LOOKUP,
    ST_SWEEP,
    ST_CLEAR,
    ST_READ,
    ST_FINISH
  } state_t;

endpackage

/* hw/rtl/mesh_route_table_top.sv */
// When the table is full, an add evicts the oldest entry before inserting; a sweep
// also clears the relayed routes through a direct neighbor that has timed out.
// One transaction in flight at a time; the slot chain is scanned one entry a cycle.
// The result strobe done is high for one cycle; the receiver cannot stall it.
// Synchronous reset empties the table and loads the timeout with 120000.
// ----------------------------------------------------------------------------
// mesh_route_table_top
// Route table built as a chain of slots with a scanning sequencer.
// ----------------------------------------------------------------------------
module mesh_route_table_top #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mrt_pkg::request_t  request,
  output logic               done,
  output mrt_pkg::response_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [31:0]        timeout;
  mrt_pkg::entry_t    entries [TABLE_DEPTH];
  mrt_pkg::cell_cmd_t cell_cmd;
  logic [IW-1:0]      cell_pos;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= mrt_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= cfg_data;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mrt_pkg::entry_t upper;
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid
      assign upper = entries[i+1];
    end
    mrt_cell #(
      .INDEX(i),
      .IW   (IW)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cell_cmd),
      .pos  (cell_pos),
      .upper(upper),
      .entry(entries[i])
    );
  end

  mrt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IW         (IW),
    .CW         (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .timeout (timeout),
    .entries (entries),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .cell_cmd(cell_cmd),
    .cell_pos(cell_pos)
  );

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("transaction not taken");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    done |-> result.entry_count <= 6'(TABLE_DEPTH) || TABLE_DEPTH > 63)
    else $error("entry count above table depth");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.found && result.changed)) else $error("found and changed both set");
`endif

endmodule

/* hw/rtl/mrt_cell.sv */
// ----------------------------------------------------------------------------
// mrt_cell
// One table slot; on a removal it takes the entry of the next slot up.
// ----------------------------------------------------------------------------
module mrt_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  mrt_pkg::cell_cmd_t cmd,
  input  logic [IW-1:0]     pos,
  input  mrt_pkg::entry_t   upper,
  output mrt_pkg::entry_t   entry
);

  logic at_pos;
  logic above_pos;

  assign at_pos    = (pos == IW'(INDEX));
  assign above_pos = (IW'(INDEX) >= pos);

  always_ff @(posedge clk) begin
    case (cmd.op)
      mrt_pkg::CELL_SHIFT: begin
        if (above_pos) begin
          entry <= upper;
        end
      end
      mrt_pkg::CELL_WRITE: begin
        if (at_pos) begin
          entry <= cmd.data;
        end
      end
      mrt_pkg::CELL_STAMP: begin
        if (at_pos) begin
          entry.stamp <= cmd.data.stamp;
        end
      end
      default: begin
      end
    endcase
    // empty slot is marked by a zero id
    if (rst) begin
      entry.id <= '0;
    end
  end

endmodule

/* hw/rtl/mrt_ctrl.sv */
// ----------------------------------------------------------------------------
// mrt_ctrl
// Sequencer that walks the slot chain for add, lookup and sweep, and reads an entry by index.
// ----------------------------------------------------------------------------
module mrt_ctrl #(
  parameter int TABLE_DEPTH = 32,
  parameter int IW          = 5,
  parameter int CW          = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mrt_pkg::request_t   request,
  input  logic [31:0]         timeout,
  input  mrt_pkg::entry_t     entries [TABLE_DEPTH],
  output logic                busy,
  output logic                done,
  output mrt_pkg::response_t  result,
  output mrt_pkg::cell_cmd_t  cell_cmd,
  output logic [IW-1:0]       cell_pos
);

  localparam int XW = (CW > 5) ? CW : 5;

  mrt_pkg::state_t state, state_next;
  mrt_pkg::request_t req;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] n, n_next;
  logic [31:0]   sweep_id, sweep_id_next;
  logic          found, found_next;
  logic          changed, changed_next;
  logic [31:0]   rid, rid_next;
  logic [31:0]   rvia, rvia_next;
  logic [7:0]    rhops, rhops_next;

  mrt_pkg::entry_t cur;
  logic in_range;
  logic match;
  logic timed_out;
  logic full;
  logic index_ok;

  assign cur       = entries[k[IW-1:0]];
  assign in_range  = (k < n);
  assign match     = (cur.id == req.node_id);
  assign timed_out = ({1'b0, req.now} > ({1'b0, cur.stamp} + {1'b0, timeout}));
  assign full      = (n == CW'(TABLE_DEPTH));
  assign index_ok  = (XW'(request.entry_index) < XW'(n));
  assign busy      = (state != mrt_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      mrt_pkg::ST_IDLE: begin
        if (start) begin
          case (request.mode)
            mrt_pkg::MODE_ADD: begin
              state_next = (request.node_id == '0) ? mrt_pkg::ST_FINISH
                                                   : mrt_pkg::ST_ADD_SCAN;
            end
            mrt_pkg::MODE_LOOKUP: begin
              state_next = (request.node_id == '0) ? mrt_pkg::ST_FINISH
                                                   : mrt_pkg::ST_LOOKUP;
            end
            mrt_pkg::MODE_SWEEP: state_next = mrt_pkg::ST_SWEEP;
            default: state_next = index_ok ? mrt_pkg::ST_READ : mrt_pkg::ST_FINISH;
          endcase
        end
      end
      mrt_pkg::ST_ADD_SCAN: begin
        if (!in_range) begin
          state_next = mrt_pkg::ST_INSERT;
        end else if (match) begin
          if (cur.via == '0) begin
            state_next = mrt_pkg::ST_FINISH;
          end else if (req.first_hop != '0 && cur.hops < req.hop_count) begin
            state_next = mrt_pkg::ST_FINISH;
          end else begin
            state_next = mrt_pkg::ST_INSERT;
          end
        end
      end
      mrt_pkg::ST_INSERT: begin
        if (!full) begin
          state_next = mrt_pkg::ST_FINISH;
        end
      end
      mrt_pkg::ST_LOOKUP: begin
        if (!in_range || match) begin
          state_next = mrt_pkg::ST_FINISH;
        end
      end
      mrt_pkg::ST_SWEEP: begin
        if (!in_range) begin
          state_next = mrt_pkg::ST_FINISH;
        end else if (timed_out && cur.via == '0) begin
          state_next = mrt_pkg::ST_CLEAR;
        end
      end
      mrt_pkg::ST_CLEAR: begin
        if (!in_range) begin
          state_next = mrt_pkg::ST_SWEEP;
        end
      end
      mrt_pkg::ST_READ:   state_next = mrt_pkg::ST_FINISH;
      mrt_pkg::ST_FINISH: state_next = mrt_pkg::ST_IDLE;
      default:            state_next = mrt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    k_next        = k;
    n_next        = n;
    sweep_id_next = sweep_id;
    found_next    = found;
    changed_next  = changed;
    rid_next      = rid;
    rvia_next     = rvia;
    rhops_next    = rhops;
    cell_cmd.op   = mrt_pkg::CELL_HOLD;
    cell_cmd.data = '{id: req.node_id, via: req.first_hop, hops: req.hop_count,
                      stamp: req.now};
    cell_pos      = k[IW-1:0];
    case (state)
      mrt_pkg::ST_IDLE: begin
        k_next       = index_ok && request.mode == mrt_pkg::MODE_READ
                       ? CW'(request.entry_index) : '0;
        found_next   = 1'b0;
        changed_next = 1'b0;
        rid_next     = '0;
        rvia_next    = '0;
        rhops_next   = '0;
      end
      mrt_pkg::ST_ADD_SCAN: begin
        if (in_range) begin
          if (match) begin
            if (cur.via == '0) begin
              // direct neighbor already known: a direct add only refreshes it
              if (req.first_hop == '0) begin
                cell_cmd.op = mrt_pkg::CELL_STAMP;
              end
            end else if (!(req.first_hop != '0 && cur.hops < req.hop_count)) begin
              cell_cmd.op = mrt_pkg::CELL_SHIFT;
              n_next      = n - 1'b1;
            end
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      mrt_pkg::ST_INSERT: begin
        if (full) begin
          // evict the oldest entry
          cell_cmd.op = mrt_pkg::CELL_SHIFT;
          cell_pos    = '0;
          n_next      = n - 1'b1;
        end else begin
          cell_cmd.op  = mrt_pkg::CELL_WRITE;
          cell_pos     = n[IW-1:0];
          n_next       = n + 1'b1;
          changed_next = 1'b1;
        end
      end
      mrt_pkg::ST_LOOKUP: begin
        if (in_range) begin
          if (match) begin
            found_next = 1'b1;
            rid_next   = cur.id;
            rvia_next  = cur.via;
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      mrt_pkg::ST_SWEEP: begin
        if (in_range) begin
          if (timed_out) begin
            cell_cmd.op  = mrt_pkg::CELL_SHIFT;
            n_next       = n - 1'b1;
            changed_next = 1'b1;
            if (cur.via == '0) begin
              sweep_id_next = cur.id;
              k_next        = '0;
            end
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      mrt_pkg::ST_CLEAR: begin
        if (!in_range) begin
          k_next = '0;
        end else if (cur.via == sweep_id) begin
          cell_cmd.op = mrt_pkg::CELL_SHIFT;
          n_next      = n - 1'b1;
        end else begin
          k_next = k + 1'b1;
        end
      end
      mrt_pkg::ST_READ: begin
        found_next = 1'b1;
        rid_next   = cur.id;
        rvia_next  = cur.via;
        rhops_next = cur.hops;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrt_pkg::ST_IDLE;
      n     <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      n     <= n_next;
      done  <= (state == mrt_pkg::ST_FINISH);
    end
    if (state == mrt_pkg::ST_IDLE && start) begin
      req <= request;
    end
    k        <= k_next;
    sweep_id <= sweep_id_next;
    found    <= found_next;
    changed  <= changed_next;
    rid      <= rid_next;
    rvia     <= rvia_next;
    rhops    <= rhops_next;
    if (state == mrt_pkg::ST_FINISH) begin
      result <= '{found: found, changed: changed, route_node_id: rid,
                  route_first_hop: rvia, route_hops: rhops, entry_count: 6'(n)};
    end
  end

endmodule
